@@ sv/bresenham_line_stepper_assert.svh @@
// Assertion macros for the line stepper modules; bls_core uses them.
// Depends on signals named clk and arst_n in the module that uses them.
// The condition must hold in the same cycle as the trigger.
`ifndef BRESENHAM_LINE_STEPPER_ASSERT_SVH
`define BRESENHAM_LINE_STEPPER_ASSERT_SVH

`define BLS_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bresenham line stepper assertion failed");

// The condition must hold in the cycle after the trigger.
`define BLS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bresenham line stepper assertion failed");

`endif

@@ sv/bls_pkg.sv @@
// Package for the Bresenham line stepper: widths, codes, setup struct, clamp.
// Depends on nothing; every module, interface and the testbench import it.
`timescale 1ns / 1ps

package bls_pkg;

	localparam int MAX_DIM = 4096;
	localparam int PIX_W = $clog2(MAX_DIM);
	localparam int CFG_W = 13;
	localparam int COORD_W = 16;
	localparam int COLOR_W = 32;
	localparam int DELTA_W = PIX_W + 1;
	localparam int TWICE_W = PIX_W + 1;
	localparam int ERR_W = PIX_W + 3;
	localparam int SZ_W = (CFG_W > PIX_W + 1) ? CFG_W : PIX_W + 1;
	localparam int CMP_W = (COORD_W > SZ_W) ? COORD_W : SZ_W;
	localparam int IDX_W = 1;

	localparam logic [CFG_W-1:0] WIDTH_RESET = CFG_W'(640);
	localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

	typedef enum logic {
		ACT_LOAD = 1'b0,
		ACT_STEP = 1'b1
	} action_t;

	typedef enum logic [IDX_W-1:0] {
		REG_SCREEN_WIDTH = 1'b0,
		REG_SCREEN_HEIGHT = 1'b1
	} reg_index_t;

	typedef struct packed {
		logic steep;
		logic active;
		logic [PIX_W-1:0] cur_major;
		logic [PIX_W-1:0] cur_minor;
		logic [PIX_W-1:0] end_major;
		logic dir_neg;
		logic [DELTA_W-1:0] major_delta;
		logic [TWICE_W-1:0] minor_twice;
	} line_setup_t;

	function automatic logic [PIX_W-1:0] clamp_coord(logic signed [COORD_W-1:0] v,
			logic [CFG_W-1:0] size);
		logic [SZ_W-1:0] eff;
		logic [SZ_W-1:0] top;
		logic [PIX_W-1:0] res;
		eff = SZ_W'(size);
		if (size == '0) begin
			eff = SZ_W'(1);
		end else if (SZ_W'(size) > SZ_W'(MAX_DIM)) begin
			eff = SZ_W'(MAX_DIM);
		end
		top = eff - SZ_W'(1);
		if (v[COORD_W-1]) begin
			res = '0;
		end else if (CMP_W'(v[COORD_W-2:0]) > CMP_W'(top)) begin
			res = top[PIX_W-1:0];
		end else begin
			res = v[PIX_W-1:0];
		end
		return res;
	endfunction

endpackage

@@ sv/bls_ifs.sv @@
// Handshake channels of the line stepper: line commands in, pixels out.
// Depends on bls_pkg for the field widths.
`timescale 1ns / 1ps

interface bls_line_if import bls_pkg::*; ();
	logic valid;
	logic ready;
	logic [0:0] action;
	logic signed [COORD_W-1:0] start_x;
	logic signed [COORD_W-1:0] start_y;
	logic signed [COORD_W-1:0] end_x;
	logic signed [COORD_W-1:0] end_y;
	logic [COLOR_W-1:0] draw_color;

	modport source (output valid, action, start_x, start_y, end_x, end_y, draw_color,
		input ready);
	modport sink (input valid, action, start_x, start_y, end_x, end_y, draw_color,
		output ready);
endinterface

interface bls_pixel_if import bls_pkg::*; ();
	logic valid;
	logic ready;
	logic [PIX_W-1:0] pixel_x;
	logic [PIX_W-1:0] pixel_y;
	logic [COLOR_W-1:0] pixel_color;
	logic last;

	modport source (output valid, pixel_x, pixel_y, pixel_color, last, input ready);
	modport sink (input valid, pixel_x, pixel_y, pixel_color, last, output ready);
endinterface

@@ sv/bls_setup.sv @@
// Line setup: clamps the endpoints, picks the major axis and orders the ends.
// Depends on bls_pkg.
`timescale 1ns / 1ps

module bls_setup import bls_pkg::*; (
	input logic signed [COORD_W-1:0] start_x,
	input logic signed [COORD_W-1:0] start_y,
	input logic signed [COORD_W-1:0] end_x,
	input logic signed [COORD_W-1:0] end_y,
	input logic [CFG_W-1:0] screen_width,
	input logic [CFG_W-1:0] screen_height,
	output line_setup_t setup
);

	logic [PIX_W-1:0] x0, y0, x1, y1;
	logic [PIX_W-1:0] dx, dy, dmin;
	logic [PIX_W-1:0] a0, b0, a1, b1;
	logic [PIX_W-1:0] lo_a, lo_b, hi_a, hi_b;
	logic steep;

	always_comb begin
		x0 = clamp_coord(start_x, screen_width);
		y0 = clamp_coord(start_y, screen_height);
		x1 = clamp_coord(end_x, screen_width);
		y1 = clamp_coord(end_y, screen_height);
		dx = (x0 > x1) ? x0 - x1 : x1 - x0;
		dy = (y0 > y1) ? y0 - y1 : y1 - y0;
		steep = dx < dy;
		a0 = steep ? y0 : x0;
		b0 = steep ? x0 : y0;
		a1 = steep ? y1 : x1;
		b1 = steep ? x1 : y1;
		if (a0 > a1) begin
			lo_a = a1;
			lo_b = b1;
			hi_a = a0;
			hi_b = b0;
		end else begin
			lo_a = a0;
			lo_b = b0;
			hi_a = a1;
			hi_b = b1;
		end
		dmin = (hi_b > lo_b) ? hi_b - lo_b : lo_b - hi_b;
		setup.steep = steep;
		setup.active = hi_a > lo_a;
		setup.cur_major = lo_a;
		setup.cur_minor = lo_b;
		setup.end_major = hi_a;
		setup.dir_neg = hi_b <= lo_b;
		setup.major_delta = DELTA_W'(hi_a - lo_a);
		setup.minor_twice = {dmin, 1'b0};
	end

endmodule

@@ sv/bls_core.sv @@
// Stepper core: holds the active line, steps the error term, drives the pixel register.
// Depends on bls_pkg, bls_ifs and the assertion macro header.
`timescale 1ns / 1ps
`include "bresenham_line_stepper_assert.svh"

module bls_core import bls_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input action_t item_action,
	input line_setup_t setup,
	input logic [COLOR_W-1:0] item_color,
	output logic adv,
	bls_pixel_if.source pix
);

	logic active_q, steep_q, dir_neg_q, out_valid_q;
	logic [PIX_W-1:0] cur_major_q, cur_minor_q, end_major_q;
	logic [DELTA_W-1:0] major_delta_q;
	logic [TWICE_W-1:0] minor_twice_q;
	logic signed [ERR_W-1:0] err_q;
	logic [COLOR_W-1:0] color_q;
	logic [PIX_W-1:0] px_q, py_q;
	logic [COLOR_W-1:0] pcolor_q;
	logic last_q;

	logic go, do_load, do_step, fin, err_gt;
	logic signed [ERR_W-1:0] err_sum, err_next;

	always_comb begin
		adv = !out_valid_q || pix.ready;
		go = item_valid && adv;
		do_load = go && (item_action == ACT_LOAD);
		do_step = go && (item_action == ACT_STEP) && active_q;
		fin = ({1'b0, cur_major_q} + DELTA_W'(1)) >= {1'b0, end_major_q};
		err_sum = err_q + $signed(ERR_W'(minor_twice_q));
		err_gt = err_sum > $signed(ERR_W'(major_delta_q));
		err_next = err_gt ? err_sum - $signed(ERR_W'({major_delta_q, 1'b0})) : err_sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_load) begin
				active_q <= setup.active;
			end else if (do_step && fin) begin
				active_q <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= do_step;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_load) begin
			steep_q <= setup.steep;
			cur_major_q <= setup.cur_major;
			cur_minor_q <= setup.cur_minor;
			end_major_q <= setup.end_major;
			dir_neg_q <= setup.dir_neg;
			major_delta_q <= setup.major_delta;
			minor_twice_q <= setup.minor_twice;
			err_q <= '0;
			color_q <= item_color;
		end else if (do_step) begin
			cur_major_q <= cur_major_q + PIX_W'(1);
			err_q <= err_next;
			if (err_gt) begin
				cur_minor_q <= dir_neg_q ? cur_minor_q - PIX_W'(1) : cur_minor_q + PIX_W'(1);
			end
		end
		if (do_step) begin
			px_q <= steep_q ? cur_minor_q : cur_major_q;
			py_q <= steep_q ? cur_major_q : cur_minor_q;
			pcolor_q <= color_q;
			last_q <= fin;
		end
	end

	assign pix.valid = out_valid_q;
	assign pix.pixel_x = px_q;
	assign pix.pixel_y = py_q;
	assign pix.pixel_color = pcolor_q;
	assign pix.last = last_q;

	// The major coordinate never reaches the end while a line is live.
	`BLS_ASSERT_SAME(a_major_below_end, active_q, cur_major_q < end_major_q)
	// The error term stays at or below the major distance.
	`BLS_ASSERT_SAME(a_err_bounded, active_q, err_q <= $signed(ERR_W'(major_delta_q)))
	// The final pixel of a line retires the line.
	`BLS_ASSERT_NEXT(a_last_ends_line, do_step && fin, !active_q)
	// A step with no live line leaves the pixel register empty.
	`BLS_ASSERT_NEXT(a_idle_step_silent, go && (item_action == ACT_STEP) && !active_q,
		!out_valid_q)

endmodule

@@ sv/bresenham_line_stepper.sv @@
// Bresenham line stepper top level: input register, screen registers, setup and core.
// Depends on bls_pkg, bls_ifs, bls_setup and bls_core.
//
//   channel    direction  handshake     payload
//   line_in    in         valid/ready   action, start_x, start_y, end_x, end_y, draw_color
//   pixel_out  out        valid/ready   pixel_x, pixel_y, pixel_color, last
//   cfg        in         cfg_we        cfg_index, cfg_data (screen_width, screen_height)
//
// One item per clock unless pixel_out stalls: an item waits in the input register, then
// setup or one error-term step runs into core state and pixel register in the same cycle.
// A step pixel is valid as its item leaves the input register. Reset clears the live line
// and both valid flags and sets the screen to 640 by 480. A stalled pixel holds the
// input register; line_in.ready follows pixel_out.ready when both stages are full.
`timescale 1ns / 1ps

module bresenham_line_stepper import bls_pkg::*; (
	input logic clk,
	input logic arst_n,
	bls_line_if.sink line_in,
	bls_pixel_if.source pixel_out,
	input logic cfg_we,
	input logic [IDX_W-1:0] cfg_index,
	input logic [CFG_W-1:0] cfg_data
);

	logic [CFG_W-1:0] width_q, height_q;
	logic valid_s1;
	action_t action_s1;
	logic signed [COORD_W-1:0] start_x_s1, start_y_s1, end_x_s1, end_y_s1;
	logic [COLOR_W-1:0] color_s1;
	logic adv;
	logic accept;
	line_setup_t setup;

	assign line_in.ready = !valid_s1 || adv;
	assign accept = line_in.valid && line_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (reg_index_t'(cfg_index))
					REG_SCREEN_WIDTH: width_q <= cfg_data;
					REG_SCREEN_HEIGHT: height_q <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= action_t'(line_in.action);
			start_x_s1 <= line_in.start_x;
			start_y_s1 <= line_in.start_y;
			end_x_s1 <= line_in.end_x;
			end_y_s1 <= line_in.end_y;
			color_s1 <= line_in.draw_color;
		end
	end

	bls_setup u_setup (
		.start_x(start_x_s1),
		.start_y(start_y_s1),
		.end_x(end_x_s1),
		.end_y(end_y_s1),
		.screen_width(width_q),
		.screen_height(height_q),
		.setup(setup)
	);

	bls_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(valid_s1),
		.item_action(action_s1),
		.setup(setup),
		.item_color(color_s1),
		.adv(adv),
		.pix(pixel_out)
	);

endmodule

@@ sim/bresenham_line_stepper_test.sv @@
// Testbench for the Bresenham line stepper: directed lines, screen limits, random lines.
// Predicts every pixel from the line commands and checks them; needs bls_pkg, bls_ifs and the RTL.
`timescale 1ns / 1ps

module bresenham_line_stepper_test;
	import bls_pkg::*;

	localparam int TWICE2_W = PIX_W + 2;

	typedef struct {
		logic [PIX_W-1:0] x;
		logic [PIX_W-1:0] y;
		logic [COLOR_W-1:0] color;
		logic last;
	} pixel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_index = REG_SCREEN_WIDTH;
	logic [CFG_W-1:0] cfg_data = '0;

	bls_line_if line_if();
	bls_pixel_if pix_if();

	bresenham_line_stepper u_top (
		.clk(clk),
		.arst_n(arst_n),
		.line_in(line_if),
		.pixel_out(pix_if),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	logic [CFG_W-1:0] scr_w = CFG_W'(640);
	logic [CFG_W-1:0] scr_h = CFG_W'(480);
	logic ln_active = 1'b0;
	logic ln_steep = 1'b0;
	logic ln_dir_neg = 1'b0;
	logic [PIX_W-1:0] ln_major = '0;
	logic [PIX_W-1:0] ln_minor = '0;
	logic [PIX_W-1:0] ln_end = '0;
	logic [DELTA_W-1:0] ln_delta = '0;
	logic [TWICE2_W-1:0] ln_twice = '0;
	logic signed [ERR_W-1:0] ln_err = '0;
	logic [COLOR_W-1:0] ln_color = '0;

	pixel_t pixels_due[$];
	int mismatch_count = 0;
	int items_sent = 0;
	int stall_left = 0;
	bit idle_on = 1'b1;

	always #5 clk = ~clk;

	function automatic int clip(input logic signed [COORD_W-1:0] v, input logic [CFG_W-1:0] size);
		int lim;
		lim = (size == 0) ? 1 : ((size > MAX_DIM) ? MAX_DIM : int'(size));
		if (v < 0) begin
			return 0;
		end
		if (int'(v) > lim - 1) begin
			return lim - 1;
		end
		return int'(v);
	endfunction

	// Updates the line state for one accepted item and queues the pixel a live step produces.
	function automatic void advance_line(input action_t act,
			input logic signed [COORD_W-1:0] sx, sy, ex, ey, input logic [COLOR_W-1:0] col);
		int x0, y0, x1, y1, a0, b0, a1, b1, t, dx, dy, dmin, e;
		pixel_t p;
		if (act == ACT_LOAD) begin
			x0 = clip(sx, scr_w);
			y0 = clip(sy, scr_h);
			x1 = clip(ex, scr_w);
			y1 = clip(ey, scr_h);
			dx = x1 - x0;
			dy = y1 - y0;
			if (dx < 0) begin
				dx = -dx;
			end
			if (dy < 0) begin
				dy = -dy;
			end
			ln_steep = dx < dy;
			if (ln_steep) begin
				a0 = y0; b0 = x0; a1 = y1; b1 = x1;
			end else begin
				a0 = x0; b0 = y0; a1 = x1; b1 = y1;
			end
			if (a0 > a1) begin
				t = a0; a0 = a1; a1 = t;
				t = b0; b0 = b1; b1 = t;
			end
			dmin = b1 - b0;
			ln_major = a0[PIX_W-1:0];
			ln_minor = b0[PIX_W-1:0];
			ln_end = a1[PIX_W-1:0];
			ln_delta = DELTA_W'(a1 - a0);
			ln_dir_neg = dmin <= 0;
			ln_twice = TWICE2_W'(((dmin < 0) ? -dmin : dmin) * 2);
			ln_err = '0;
			ln_color = col;
			ln_active = a1 > a0;
		end else if (ln_active) begin
			p.x = ln_steep ? ln_minor : ln_major;
			p.y = ln_steep ? ln_major : ln_minor;
			p.color = ln_color;
			p.last = (int'(ln_major) + 1) >= int'(ln_end);
			pixels_due.push_back(p);
			e = int'(ln_err) + int'(ln_twice);
			if (e > int'(ln_delta)) begin
				ln_minor = ln_dir_neg ? ln_minor - 1'b1 : ln_minor + 1'b1;
				e = e - 2 * int'(ln_delta);
			end
			ln_err = e[ERR_W-1:0];
			ln_major = ln_major + 1'b1;
			if (p.last) begin
				ln_active = 1'b0;
			end
		end
	endfunction

	function automatic logic signed [COORD_W-1:0] pick_coord(input logic [CFG_W-1:0] size);
		case ($urandom_range(0, 9))
			0: return COORD_W'($urandom);
			1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			2: return COORD_W'(-$urandom_range(1, 5));
			default: return COORD_W'($urandom_range(0, int'(size) + 2));
		endcase
	endfunction

	task automatic send_item(input action_t act,
			input logic signed [COORD_W-1:0] sx, sy, ex, ey, input logic [COLOR_W-1:0] col);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			line_if.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		line_if.valid <= 1'b1;
		line_if.action <= act;
		line_if.start_x <= sx;
		line_if.start_y <= sy;
		line_if.end_x <= ex;
		line_if.end_y <= ey;
		line_if.draw_color <= col;
		do @(posedge clk); while (!line_if.ready);
		advance_line(act, sx, sy, ex, ey, col);
		items_sent++;
	endtask

	// Load fields carry junk on a step item; the block must ignore them.
	task automatic send_step();
		send_item(ACT_STEP, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
			COORD_W'($urandom), $urandom);
	endtask

	// A load leaves no pixel behind, so the task also waits out an item still in flight.
	task automatic wait_idle();
		line_if.valid <= 1'b0;
		while (pixels_due.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic set_screen(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= REG_SCREEN_WIDTH;
		cfg_data <= w;
		@(posedge clk);
		cfg_index <= REG_SCREEN_HEIGHT;
		cfg_data <= h;
		@(posedge clk);
		cfg_we <= 1'b0;
		scr_w = w;
		scr_h = h;
	endtask

	task automatic test_directed();
		send_step();
		send_item(ACT_LOAD, 3, 5, 3, 5, 32'h0000_0000);
		send_step();
		send_item(ACT_LOAD, -32768, 32767, 32767, -32768, 32'hFFFF_FFFF);
		repeat (3) send_step();
		send_item(ACT_LOAD, 10, 10, 12, 17, 32'h1234_5678);
		repeat (8) send_step();
		send_item(ACT_LOAD, 20, 4, 16, 4, 32'hA5A5_5A5A);
		repeat (4) send_step();
		send_item(ACT_LOAD, 100, 300, 97, 290, 32'h5A5A_A5A5);
		repeat (3) send_step();
	endtask

	task automatic test_screen_limits();
		set_screen(0, 0);
		send_item(ACT_LOAD, 5, -7, 900, 32767, $urandom);
		repeat (2) send_step();
		set_screen(8191, 4097);
		send_item(ACT_LOAD, -1, -1, 32767, 32767, $urandom);
		repeat (5) send_step();
		send_item(ACT_LOAD, 4095, 0, 4094, 4095, $urandom);
		repeat (5) send_step();
		set_screen(1, 4096);
		send_item(ACT_LOAD, 0, 0, 0, 4095, $urandom);
		repeat (4) send_step();
		set_screen(4096, 1);
		send_item(ACT_LOAD, 4095, 7, 4090, -3, $urandom);
		repeat (6) send_step();
	endtask

	task automatic test_random_lines();
		int steps;
		int phase_end;
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: set_screen($urandom_range(2, 40), $urandom_range(2, 40));
				1: set_screen($urandom_range(1, 12), $urandom_range(1, 12));
				2: set_screen($urandom_range(41, 200), $urandom_range(41, 200));
				3: set_screen(4096, 4096);
				4: set_screen($urandom_range(0, 8191), $urandom_range(0, 8191));
				default: set_screen($urandom_range(2, 64), $urandom_range(2, 64));
			endcase
			idle_on = (phase != 2) && (phase != 5);
			phase_end = items_sent + 220;
			while (items_sent < phase_end) begin
				if ($urandom_range(0, 9) == 0) begin
					send_item(action_t'($urandom_range(0, 1)), COORD_W'($urandom),
						COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom), $urandom);
				end else begin
					send_item(ACT_LOAD, pick_coord(scr_w), pick_coord(scr_h),
						pick_coord(scr_w), pick_coord(scr_h), $urandom);
					steps = ln_active ? int'(ln_end) - int'(ln_major) : 0;
					case ($urandom_range(0, 7))
						0: steps = $urandom_range(0, steps);
						1: steps = steps + $urandom_range(1, 3);
						default: ;
					endcase
					if (steps > 48) begin
						steps = $urandom_range(24, 48);
					end
					repeat (steps) send_step();
				end
			end
		end
	endtask

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			pix_if.ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 14) - 1;
			pix_if.ready <= 1'b0;
		end else begin
			pix_if.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		pixel_t want;
		if (arst_n && pix_if.valid && pix_if.ready) begin
			if (pixels_due.size() == 0) begin
				$error("pixel with no item waiting: x %0d y %0d", pix_if.pixel_x, pix_if.pixel_y);
				mismatch_count++;
			end else begin
				want = pixels_due.pop_front();
				if (pix_if.pixel_x !== want.x) begin
					$error("pixel_x: expected %0d, actual %0d", want.x, pix_if.pixel_x);
					mismatch_count++;
				end
				if (pix_if.pixel_y !== want.y) begin
					$error("pixel_y: expected %0d, actual %0d", want.y, pix_if.pixel_y);
					mismatch_count++;
				end
				if (pix_if.pixel_color !== want.color) begin
					$error("pixel_color: expected %h, actual %h", want.color, pix_if.pixel_color);
					mismatch_count++;
				end
				if (pix_if.last !== want.last) begin
					$error("last: expected %0d, actual %0d", want.last, pix_if.last);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		line_if.valid = 1'b0;
		line_if.action = ACT_LOAD;
		line_if.start_x = '0;
		line_if.start_y = '0;
		line_if.end_x = '0;
		line_if.end_y = '0;
		line_if.draw_color = '0;
		pix_if.ready = 1'b1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_screen_limits();
		test_random_lines();
		wait_idle();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+sv
sv/bls_pkg.sv
sv/bls_ifs.sv
sv/bls_setup.sv
sv/bls_core.sv
sv/bresenham_line_stepper.sv
sim/bresenham_line_stepper_test.sv
